// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/mcsp_pkg.sv
// Types and constants of the mesh chunk stream parser.
// Has no dependencies; used by all modules of the parser.
package mcsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } mcsp_in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [31:0] record_value;
    logic [15:0] element_index;
    logic [1:0]  component;
    logic        last_of_list;
  } mcsp_out_t;

  localparam logic [15:0] ID_MAIN     = 16'h4d4d;
  localparam logic [15:0] ID_EDITOR   = 16'h3d3d;
  localparam logic [15:0] ID_OBJECT   = 16'h4000;
  localparam logic [15:0] ID_TRIMESH  = 16'h4100;
  localparam logic [15:0] ID_VERTICES = 16'h4110;
  localparam logic [15:0] ID_FACES    = 16'h4120;
  localparam logic [15:0] ID_MAPPING  = 16'h4140;

  localparam logic [31:0] HEADER_LEN = 32'd6;

  localparam logic [2:0] KIND_NAME_BYTE = 3'd0;
  localparam logic [2:0] KIND_NAME_END  = 3'd1;
  localparam logic [2:0] KIND_VERTEX    = 3'd2;
  localparam logic [2:0] KIND_FACE      = 3'd3;
  localparam logic [2:0] KIND_TEXCOORD  = 3'd4;
  localparam logic [2:0] KIND_FORMAT    = 3'd5;

endpackage

// File: sv/mcsp_parse.sv
// Parse state of the chunk stream and the per-byte decode logic.
// Depends on mcsp_pkg for the transaction types, chunk ids and record kinds.
module mcsp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mcsp_pkg::mcsp_in_t item_i,
  output logic               res_valid_o,
  output mcsp_pkg::mcsp_out_t res_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_COUNT,
    PH_LIST,
    PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d, cur_phase;
  logic [2:0]  bif_q, bif_d, cur_bif;
  logic [31:0] fa_q, fa_d, cur_fa;
  logic [15:0] id_q, id_d, cur_id;
  logic [31:0] skip_q, skip_d, cur_skip;
  logic [15:0] total_q, total_d, cur_total;
  logic [15:0] lpos_q, lpos_d, cur_lpos;
  logic [1:0]  comp_q, comp_d, cur_comp;

  logic [7:0]  b;
  logic [1:0]  byte_shift;
  logic [2:0]  hdr_k;
  logic [2:0]  hdr_k_off;
  logic [31:0] fa_new;
  logic [31:0] skip_dec;
  logic [15:0] lpos_inc;
  logic        elem_done;
  logic        is_face;
  logic        is_map;
  logic        word_done;
  logic [1:0]  ncomp_m1;
  logic [1:0]  comp_cl;
  logic [1:0]  comp_inc;

  assign b         = item_i.data_byte;
  assign cur_phase = item_i.file_start ? PH_HEADER : phase_q;
  assign cur_bif   = item_i.file_start ? 3'd0 : bif_q;
  assign cur_fa    = item_i.file_start ? 32'd0 : fa_q;
  assign cur_id    = item_i.file_start ? 16'd0 : id_q;
  assign cur_skip  = item_i.file_start ? 32'd0 : skip_q;
  assign cur_total = item_i.file_start ? 16'd0 : total_q;
  assign cur_lpos  = item_i.file_start ? 16'd0 : lpos_q;
  assign cur_comp  = item_i.file_start ? 2'd0 : comp_q;

  assign hdr_k     = (cur_bif > 3'd5) ? 3'd5 : cur_bif;
  assign hdr_k_off = hdr_k - 3'd2;
  assign is_face   = (cur_id == mcsp_pkg::ID_FACES);
  assign is_map    = (cur_id == mcsp_pkg::ID_MAPPING);
  assign word_done = is_face ? (cur_bif[1:0] != 2'd0) : (cur_bif[1:0] == 2'd3);
  assign ncomp_m1  = is_map ? 2'd1 : 2'd2;
  assign comp_cl   = (cur_comp > ncomp_m1) ? ncomp_m1 : cur_comp;
  assign comp_inc  = comp_cl + 2'd1;
  assign lpos_inc  = cur_lpos + 16'd1;
  assign elem_done = (lpos_inc >= cur_total);
  assign skip_dec  = (cur_skip != 32'd0) ? (cur_skip - 32'd1) : cur_skip;

  always_comb begin
    case (cur_phase)
      PH_HEADER: byte_shift = (cur_bif < 3'd2) ? cur_bif[1:0] : hdr_k_off[1:0];
      PH_COUNT:  byte_shift = {1'b0, cur_bif[0]};
      PH_LIST:   byte_shift = cur_bif[1:0];
      default:   byte_shift = 2'd0;
    endcase
  end

  assign fa_new = cur_fa | ({24'd0, b} << {byte_shift, 3'b000});

  always_comb begin
    phase_d     = cur_phase;
    bif_d       = cur_bif;
    fa_d        = cur_fa;
    id_d        = cur_id;
    skip_d      = cur_skip;
    total_d     = cur_total;
    lpos_d      = cur_lpos;
    comp_d      = cur_comp;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (cur_phase)
      PH_NAME: begin
        res_valid_o         = 1'b1;
        res_o.element_index = cur_lpos;
        if (b == 8'd0) begin
          phase_d           = PH_HEADER;
          bif_d             = 3'd0;
          fa_d              = 32'd0;
          res_o.record_kind = mcsp_pkg::KIND_NAME_END;
        end else begin
          res_o.record_kind  = mcsp_pkg::KIND_NAME_BYTE;
          res_o.record_value = {24'd0, b};
          lpos_d             = lpos_inc;
        end
      end
      PH_COUNT: begin
        if (!cur_bif[0]) begin
          fa_d  = fa_new;
          bif_d = 3'd1;
        end else begin
          total_d = fa_new[15:0];
          bif_d   = 3'd0;
          fa_d    = 32'd0;
          lpos_d  = 16'd0;
          comp_d  = 2'd0;
          phase_d = (fa_new[15:0] == 16'd0) ? PH_HEADER : PH_LIST;
        end
      end
      PH_LIST: begin
        if (!word_done) begin
          fa_d  = fa_new;
          bif_d = {1'b0, cur_bif[1:0]} + 3'd1;
        end else begin
          bif_d = 3'd0;
          fa_d  = 32'd0;
          if (is_face && cur_comp == 2'd3) begin
            comp_d = 2'd0;
            lpos_d = lpos_inc;
            if (elem_done) begin
              phase_d = PH_HEADER;
            end
          end else begin
            res_valid_o         = 1'b1;
            res_o.record_kind   = is_face ? mcsp_pkg::KIND_FACE :
                                  (is_map ? mcsp_pkg::KIND_TEXCOORD : mcsp_pkg::KIND_VERTEX);
            res_o.record_value  = is_face ? {16'd0, fa_new[15:0]} : fa_new;
            res_o.element_index = cur_lpos;
            res_o.component     = comp_cl;
            res_o.last_of_list  = ({1'b0, cur_lpos} + 17'd1 == {1'b0, cur_total}) &&
                                  (comp_cl == ncomp_m1);
            if (is_face || comp_cl != ncomp_m1) begin
              comp_d = comp_inc;
            end else begin
              comp_d = 2'd0;
              lpos_d = lpos_inc;
              if (elem_done) begin
                phase_d = PH_HEADER;
              end
            end
          end
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_d = PH_HEADER;
          bif_d   = 3'd0;
          fa_d    = 32'd0;
        end
      end
      default: begin
        if (cur_bif < 3'd2) begin
          bif_d = cur_bif + 3'd1;
          if (cur_bif == 3'd1) begin
            id_d = fa_new[15:0];
            fa_d = 32'd0;
          end else begin
            fa_d = fa_new;
          end
        end else if (hdr_k < 3'd5) begin
          fa_d  = fa_new;
          bif_d = hdr_k + 3'd1;
        end else begin
          phase_d = PH_HEADER;
          bif_d   = 3'd0;
          fa_d    = 32'd0;
          unique case (cur_id) inside
            mcsp_pkg::ID_MAIN, mcsp_pkg::ID_EDITOR, mcsp_pkg::ID_TRIMESH: begin
            end
            mcsp_pkg::ID_OBJECT: begin
              phase_d = PH_NAME;
              lpos_d  = 16'd0;
            end
            mcsp_pkg::ID_VERTICES, mcsp_pkg::ID_FACES, mcsp_pkg::ID_MAPPING: begin
              phase_d = PH_COUNT;
            end
            default: begin
              if (fa_new < mcsp_pkg::HEADER_LEN) begin
                res_valid_o         = 1'b1;
                res_o.record_kind   = mcsp_pkg::KIND_FORMAT;
                res_o.record_value  = fa_new;
                res_o.element_index = cur_id;
              end else begin
                skip_d = fa_new - mcsp_pkg::HEADER_LEN;
                if (fa_new != mcsp_pkg::HEADER_LEN) begin
                  phase_d = PH_SKIP;
                end
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      bif_q   <= 3'd0;
      fa_q    <= 32'd0;
      id_q    <= 16'd0;
      skip_q  <= 32'd0;
      total_q <= 16'd0;
      lpos_q  <= 16'd0;
      comp_q  <= 2'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      fa_q    <= fa_d;
      id_q    <= id_d;
      skip_q  <= skip_d;
      total_q <= total_d;
      lpos_q  <= lpos_d;
      comp_q  <= comp_d;
    end
  end

endmodule

// File: sv/mesh_chunk_stream_parser.sv
// Top level of the mesh chunk stream parser: input register, parse stage, result register.
// Depends on mcsp_pkg and mcsp_parse.
// An accepted input transaction waits in the input register and is decoded by the parse
// stage; its result, if any, is captured in the result register.
// Throughput: one byte per cycle; the input register only holds while a result is stalled.
// Reset: asynchronous, active low; clears both valid flags and all parse state.
module mesh_chunk_stream_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mcsp_pkg::mcsp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mcsp_pkg::mcsp_out_t out_data_o
);

  logic                in_valid_q;
  mcsp_pkg::mcsp_in_t  in_q;
  logic                out_valid_q;
  mcsp_pkg::mcsp_out_t out_q;
  logic                advance;
  logic                res_valid;
  mcsp_pkg::mcsp_out_t res;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  mcsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/mcsp_checker.sv
// Port-level checks of the mesh chunk stream parser, bound to its top level.
// Depends on mcsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mcsp_pkg::mcsp_out_t out_data_o
);

  logic in_taken;
  logic plain_kind;
  logic zero_extras;

  assign in_taken    = in_valid_i && !in_stall_o;
  assign plain_kind  = out_data_o.record_kind inside {mcsp_pkg::KIND_NAME_BYTE,
                                                      mcsp_pkg::KIND_NAME_END,
                                                      mcsp_pkg::KIND_FORMAT};
  assign zero_extras = (out_data_o.component == 2'd0) && !out_data_o.last_of_list;

  `ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  `ASSERT_SAME(a_result_latency, clk_i, rst_ni, $rose(out_valid_o), $past(in_taken, 2))
  `ASSERT_SAME(a_plain_kinds, clk_i, rst_ni, out_valid_o && plain_kind, zero_extras)

endmodule

bind mesh_chunk_stream_parser mcsp_checker u_mcsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
